// File: sv/optimal_bst_cost_unit_assert.svh
// ----------------------------------------------------------------------------
// Optimal BST cost unit assertion macros
// Concurrent assertion wrappers shared by obst_cmp and obst_ctrl; compiled out when
// NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef OPTIMAL_BST_COST_UNIT_ASSERT_SVH
`define OPTIMAL_BST_COST_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Plain property, sampled on clk, off while reset is asserted
`define OBST_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("obst assertion failed");

// Same-cycle implication
`define OBST_ASSERT_IMP(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("obst assertion failed");

// Next-cycle implication
`define OBST_ASSERT_NXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("obst assertion failed");

`else

`define OBST_ASSERT(name, clk, rst_n, prop)
`define OBST_ASSERT_IMP(name, clk, rst_n, ante, cons)
`define OBST_ASSERT_NXT(name, clk, rst_n, ante, cons)

`endif

`endif

// File: sv/obst_pkg.sv
// ----------------------------------------------------------------------------
// Optimal BST cost package
// Field widths, transaction payload types and the compare-unit command.
// ----------------------------------------------------------------------------
package obst_pkg;

  localparam int DEF_MAX_KEYS = 16;
  localparam int FREQ_W       = 16;
  localparam int COST_W       = 24;

  localparam logic [COST_W-1:0] COST_MAX = '1;

  // Input transaction: one key frequency
  typedef struct packed {
    logic [FREQ_W-1:0] frequency;
    logic              last_key;
  } in_item_t;

  // Output transaction: cost of the optimal tree
  typedef struct packed {
    logic [COST_W-1:0] total_cost;
    logic              overflow;
  } out_item_t;

  // One root candidate issued to the compare unit
  typedef struct packed {
    logic valid;
    logic first;   // first root of the interval
    logic last;    // last root of the interval
    logic lmask;   // left subtree empty
    logic rmask;   // right subtree empty
  } cmp_cmd_t;

endpackage

// File: sv/obst_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module obst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/obst_cmp.sv
// ----------------------------------------------------------------------------
// Optimal BST compare unit
// Shared add/min unit: sums the two subtree costs of one root candidate,
// keeps the running minimum and forms the saturated interval cost.
// ----------------------------------------------------------------------------
`include "optimal_bst_cost_unit_assert.svh"

module obst_cmp #(
  parameter int MAX_KEYS = obst_pkg::DEF_MAX_KEYS,
  localparam int CW      = obst_pkg::COST_W,
  localparam int PW      = obst_pkg::FREQ_W + $clog2(MAX_KEYS),
  localparam int SW      = (((CW + 1) > PW) ? (CW + 1) : PW) + 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  obst_pkg::cmp_cmd_t  cmd_i,
  input  logic [CW-1:0]       lcost_i,
  input  logic [CW-1:0]       rcost_i,
  input  logic [PW-1:0]       weight_i,
  output logic [CW-1:0]       final_cost_o
);

  obst_pkg::cmp_cmd_t cmd_q;
  logic [CW:0]        best_q, best_d;
  logic [CW:0]        pair_sum;
  logic [SW-1:0]      total;

  // candidate cost, empty subtrees count as zero
  assign pair_sum = (cmd_q.lmask ? '0 : {1'b0, lcost_i})
                  + (cmd_q.rmask ? '0 : {1'b0, rcost_i});

  // running minimum over roots
  always_comb begin
    best_d = best_q;
    if (cmd_q.valid) begin
      if (cmd_q.first || (pair_sum < best_q)) begin
        best_d = pair_sum;
      end
    end
  end

  // interval cost = min + weight, saturated
  assign total        = SW'(best_d) + SW'(weight_i);
  assign final_cost_o = (total > SW'(obst_pkg::COST_MAX)) ? obst_pkg::COST_MAX
                                                          : total[CW-1:0];

  // command lines up with registered RAM read data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_q  <= '0;
      best_q <= '0;
    end else begin
      cmd_q  <= cmd_i;
      best_q <= best_d;
    end
  end

  // roots of one interval arrive back to back
  `OBST_ASSERT_IMP(a_run_contiguous, clk_i, rst_ni, cmd_q.valid && !cmd_q.first, $past(cmd_q.valid))
  // the last root is followed by a gap for the table write
  `OBST_ASSERT_NXT(a_gap_after_last, clk_i, rst_ni, cmd_q.valid && cmd_q.last, !cmd_q.valid)

endmodule

// File: sv/obst_ctrl.sv
// ----------------------------------------------------------------------------
// Optimal BST sequencer
// Loads prefix sums of the key frequencies, then walks all intervals by
// length, issuing one root candidate per cycle within each interval to the
// compare unit, and holds the result in the output register.
// ----------------------------------------------------------------------------
`include "optimal_bst_cost_unit_assert.svh"

module obst_ctrl #(
  parameter int MAX_KEYS = obst_pkg::DEF_MAX_KEYS,
  localparam int KW      = $clog2(MAX_KEYS + 1),
  localparam int IW      = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1,
  localparam int AW      = ((MAX_KEYS * MAX_KEYS) > 1) ? $clog2(MAX_KEYS * MAX_KEYS) : 1,
  localparam int PW      = obst_pkg::FREQ_W + $clog2(MAX_KEYS),
  localparam int CW      = obst_pkg::COST_W
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // input channel
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  obst_pkg::in_item_t  in_data_i,
  // output channel
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output obst_pkg::out_item_t out_data_o,
  // prefix sum RAMs
  output logic                psum_we_o,
  output logic [KW-1:0]       psum_waddr_o,
  output logic [PW-1:0]       psum_wdata_o,
  output logic [KW-1:0]       psum_raddr_a_o,
  output logic [KW-1:0]       psum_raddr_b_o,
  input  logic [PW-1:0]       psum_rdata_a_i,
  input  logic [PW-1:0]       psum_rdata_b_i,
  // interval cost RAMs
  output logic                cost_we_o,
  output logic [AW-1:0]       cost_waddr_o,
  output logic [AW-1:0]       cost_raddr_l_o,
  output logic [AW-1:0]       cost_raddr_r_o,
  // compare unit
  output obst_pkg::cmp_cmd_t  cmd_o,
  output logic [PW-1:0]       weight_o,
  input  logic [CW-1:0]       final_cost_i
);

  typedef enum logic [2:0] {
    S_LOAD,
    S_START,
    S_CALC,
    S_DRAIN,
    S_FINISH
  } state_e;

  state_e              state_q, state_d;
  logic [KW-1:0]       count_q, count_d;
  logic [PW-1:0]       sum_q, sum_d;
  logic                ovf_q, ovf_d;
  logic [KW-1:0]       n_q, n_d;
  logic [KW-1:0]       len_q, len_d;
  logic [IW-1:0]       lo_q, lo_d;
  logic [IW-1:0]       r_q, r_d;
  logic [PW-1:0]       weight_q, weight_d;
  logic [CW-1:0]       final_q, final_d;
  logic                out_valid_q, out_valid_d;
  obst_pkg::out_item_t out_data_q, out_data_d;

  logic [KW-1:0]       hi_full;
  logic [KW-1:0]       end_excl;
  logic [IW-1:0]       hi_idx;
  logic                root_first;
  logic                root_last;

  // table cell of interval row..col
  function automatic logic [AW-1:0] cell_addr(logic [IW-1:0] row, logic [IW-1:0] col);
    cell_addr = AW'(row) * AW'(MAX_KEYS) + AW'(col);
  endfunction

  // current interval bounds
  assign end_excl   = KW'(lo_q) + len_q;
  assign hi_full    = end_excl - KW'(1);
  assign hi_idx     = hi_full[IW-1:0];
  assign root_first = (r_q == lo_q);
  assign root_last  = (r_q == hi_idx);

  // memory addressing
  assign psum_waddr_o   = count_q + KW'(1);
  assign psum_wdata_o   = sum_q + PW'(in_data_i.frequency);
  assign psum_raddr_a_o = end_excl;
  assign psum_raddr_b_o = KW'(lo_q);
  assign cost_waddr_o   = cell_addr(lo_q, hi_idx);
  assign cost_raddr_l_o = (state_q == S_CALC && !root_first)
                        ? cell_addr(lo_q, r_q - IW'(1)) : '0;
  assign cost_raddr_r_o = (state_q == S_CALC && !root_last)
                        ? cell_addr(r_q + IW'(1), hi_idx) : '0;

  assign in_ready_o  = (state_q == S_LOAD);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign weight_o    = weight_q;

  // next-state logic
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    sum_d       = sum_q;
    ovf_d       = ovf_q;
    n_d         = n_q;
    len_d       = len_q;
    lo_d        = lo_q;
    r_d         = r_q;
    weight_d    = weight_q;
    final_d     = final_q;
    out_data_d  = out_data_q;
    out_valid_d = out_valid_q;
    psum_we_o   = 1'b0;
    cost_we_o   = 1'b0;
    cmd_o       = '0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_LOAD: begin
        if (in_valid_i) begin
          if (count_q < KW'(MAX_KEYS)) begin
            psum_we_o = 1'b1;
            sum_d     = psum_wdata_o;
            count_d   = count_q + KW'(1);
          end else begin
            ovf_d = 1'b1;
          end
          if (in_data_i.last_key) begin
            n_d     = count_d;
            len_d   = KW'(1);
            lo_d    = '0;
            state_d = S_START;
          end
        end
      end
      S_START: begin
        r_d     = lo_q;
        state_d = S_CALC;
      end
      S_CALC: begin
        // prefix reads settle during the first root cycle
        if (root_first) begin
          weight_d = psum_rdata_a_i - ((lo_q == '0) ? '0 : psum_rdata_b_i);
        end
        cmd_o.valid = 1'b1;
        cmd_o.first = root_first;
        cmd_o.last  = root_last;
        cmd_o.lmask = root_first;
        cmd_o.rmask = root_last;
        if (root_last) begin
          state_d = S_DRAIN;
        end else begin
          r_d = r_q + IW'(1);
        end
      end
      S_DRAIN: begin
        cost_we_o = 1'b1;
        if (end_excl < n_q) begin
          lo_d    = lo_q + IW'(1);
          state_d = S_START;
        end else if (len_q < n_q) begin
          len_d   = len_q + KW'(1);
          lo_d    = '0;
          state_d = S_START;
        end else begin
          final_d = final_cost_i;
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          out_data_d.total_cost = final_q;
          out_data_d.overflow   = ovf_q;
          out_valid_d           = 1'b1;
          count_d               = '0;
          sum_d                 = '0;
          ovf_d                 = 1'b0;
          state_d               = S_LOAD;
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_LOAD;
      count_q     <= '0;
      sum_q       <= '0;
      ovf_q       <= 1'b0;
      n_q         <= '0;
      len_q       <= '0;
      lo_q        <= '0;
      r_q         <= '0;
      weight_q    <= '0;
      final_q     <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      sum_q       <= sum_d;
      ovf_q       <= ovf_d;
      n_q         <= n_d;
      len_q       <= len_d;
      lo_q        <= lo_d;
      r_q         <= r_d;
      weight_q    <= weight_d;
      final_q     <= final_d;
      out_valid_q <= out_valid_d;
      out_data_q  <= out_data_d;
    end
  end

  // key count never passes the table size
  `OBST_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= KW'(MAX_KEYS))
  // root stays inside its interval
  `OBST_ASSERT_IMP(a_root_in_range, clk_i, rst_ni, state_q == S_CALC, (r_q >= lo_q) && (r_q <= hi_idx))
  // result taken from the full key range
  `OBST_ASSERT_IMP(a_final_interval, clk_i, rst_ni, state_q == S_FINISH, (lo_q == '0) && (len_q == n_q))

endmodule

// File: sv/optimal_bst_cost_unit.sv
// ----------------------------------------------------------------------------
// Optimal BST cost unit
// Least weighted search cost of a binary search tree over a set of sorted
// keys, from their access frequencies, by bottom-up interval tables.
// ----------------------------------------------------------------------------
//
//   channel | direction | payload    | handshake
//   --------+-----------+------------+------------------------------
//   in      | input     | in_item_t  | in_valid_i  / in_ready_o
//   out     | output    | out_item_t | out_valid_o / out_ready_i
//
// Each key is loaded as a prefix sum. The solve after the last key of a set is
// paced by the single add/min unit, which tests one root per cycle within an
// interval against one pair of interval-cost reads.
// The input is not ready during the solve, nor while a finished result waits
// for the previous one to leave the output register.
// Reset needs no clearing pass; only entries written in the current set are read.

module optimal_bst_cost_unit #(
  parameter int MAX_KEYS = obst_pkg::DEF_MAX_KEYS
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  obst_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output obst_pkg::out_item_t out_data_o
);

  localparam int KW = $clog2(MAX_KEYS + 1);
  localparam int AW = ((MAX_KEYS * MAX_KEYS) > 1) ? $clog2(MAX_KEYS * MAX_KEYS) : 1;
  localparam int PW = obst_pkg::FREQ_W + $clog2(MAX_KEYS);
  localparam int CW = obst_pkg::COST_W;

  logic               psum_we;
  logic [KW-1:0]      psum_waddr;
  logic [PW-1:0]      psum_wdata;
  logic [KW-1:0]      psum_raddr_a, psum_raddr_b;
  logic [PW-1:0]      psum_rdata_a, psum_rdata_b;
  logic               cost_we;
  logic [AW-1:0]      cost_waddr;
  logic [AW-1:0]      cost_raddr_l, cost_raddr_r;
  logic [CW-1:0]      cost_rdata_l, cost_rdata_r;
  logic [CW-1:0]      final_cost;
  logic [PW-1:0]      weight;
  obst_pkg::cmp_cmd_t cmd;

  // sequencer
  obst_ctrl #(
    .MAX_KEYS (MAX_KEYS)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .in_data_i      (in_data_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_data_o     (out_data_o),
    .psum_we_o      (psum_we),
    .psum_waddr_o   (psum_waddr),
    .psum_wdata_o   (psum_wdata),
    .psum_raddr_a_o (psum_raddr_a),
    .psum_raddr_b_o (psum_raddr_b),
    .psum_rdata_a_i (psum_rdata_a),
    .psum_rdata_b_i (psum_rdata_b),
    .cost_we_o      (cost_we),
    .cost_waddr_o   (cost_waddr),
    .cost_raddr_l_o (cost_raddr_l),
    .cost_raddr_r_o (cost_raddr_r),
    .cmd_o          (cmd),
    .weight_o       (weight),
    .final_cost_i   (final_cost)
  );

  // shared add/min unit
  obst_cmp #(
    .MAX_KEYS (MAX_KEYS)
  ) u_cmp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .lcost_i      (cost_rdata_l),
    .rcost_i      (cost_rdata_r),
    .weight_i     (weight),
    .final_cost_o (final_cost)
  );

  // prefix sums, two copies for the two interval ends
  obst_ram #(
    .WIDTH (PW),
    .DEPTH (MAX_KEYS + 1)
  ) u_psum_a (
    .clk_i   (clk_i),
    .we_i    (psum_we),
    .waddr_i (psum_waddr),
    .wdata_i (psum_wdata),
    .raddr_i (psum_raddr_a),
    .rdata_o (psum_rdata_a)
  );

  obst_ram #(
    .WIDTH (PW),
    .DEPTH (MAX_KEYS + 1)
  ) u_psum_b (
    .clk_i   (clk_i),
    .we_i    (psum_we),
    .waddr_i (psum_waddr),
    .wdata_i (psum_wdata),
    .raddr_i (psum_raddr_b),
    .rdata_o (psum_rdata_b)
  );

  // interval costs, two copies for the left and right subtrees
  obst_ram #(
    .WIDTH (CW),
    .DEPTH (MAX_KEYS * MAX_KEYS)
  ) u_cost_l (
    .clk_i   (clk_i),
    .we_i    (cost_we),
    .waddr_i (cost_waddr),
    .wdata_i (final_cost),
    .raddr_i (cost_raddr_l),
    .rdata_o (cost_rdata_l)
  );

  obst_ram #(
    .WIDTH (CW),
    .DEPTH (MAX_KEYS * MAX_KEYS)
  ) u_cost_r (
    .clk_i   (clk_i),
    .we_i    (cost_we),
    .waddr_i (cost_waddr),
    .wdata_i (final_cost),
    .raddr_i (cost_raddr_r),
    .rdata_o (cost_rdata_r)
  );

endmodule

// File: tb/optimal_bst_cost_checker.sv
// ----------------------------------------------------------------------------
// Optimal BST cost checker
// Watches both channels of the cost unit. It mirrors the key store for each
// accepted input transaction. On the last key of a set it computes the least
// weighted tree cost bottom-up over all key intervals. Each output
// transaction is compared field by field with the oldest cost still due.
// ----------------------------------------------------------------------------
module optimal_bst_cost_checker #(
  parameter int MAX_KEYS = obst_pkg::DEF_MAX_KEYS
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  obst_pkg::in_item_t  in_data_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  obst_pkg::out_item_t out_data_i,
  output int unsigned         fail_count_o,
  output int unsigned         due_count_o
);

  // Mirror of the key store
  logic [obst_pkg::FREQ_W-1:0] freq_mirror [MAX_KEYS];
  int unsigned                 keys_held   = 0;
  logic                        excess_seen = 1'b0;

  // Costs still due on the output channel, oldest first
  obst_pkg::out_item_t cost_due_q [$];

  int unsigned fail_count = 0;
  int unsigned due_count  = 0;

  assign fail_count_o = fail_count;
  assign due_count_o  = due_count;

  // Least weighted search cost over the first n held keys, root at depth 1
  function automatic logic [obst_pkg::COST_W-1:0] min_tree_cost(input int unsigned n);
    logic [31:0] psum [MAX_KEYS+1];
    logic [31:0] span_cost [MAX_KEYS][MAX_KEYS];
    logic [31:0] best;
    logic [31:0] cand;
    logic [31:0] weight;
    logic [31:0] total;
    int          hi;
    psum[0] = '0;
    for (int i = 0; i < n; i++) psum[i+1] = psum[i] + 32'(freq_mirror[i]);
    for (int len = 1; len <= n; len++) begin
      for (int lo = 0; lo + len <= n; lo++) begin
        hi     = lo + len - 1;
        weight = psum[hi+1] - psum[lo];
        best   = '1;
        // try every root; an empty side costs nothing
        for (int r = lo; r <= hi; r++) begin
          cand = ((r > lo) ? span_cost[lo][r-1] : 32'd0) +
                 ((r < hi) ? span_cost[r+1][hi] : 32'd0);
          if (cand < best) best = cand;
        end
        total = best + weight;
        span_cost[lo][hi] = (total > 32'(obst_pkg::COST_MAX)) ? 32'(obst_pkg::COST_MAX)
                                                              : total;
      end
    end
    return span_cost[0][n-1][obst_pkg::COST_W-1:0];
  endfunction

  // Output side first, then the input transaction of the same edge
  always @(posedge clk_i) begin
    obst_pkg::out_item_t due;
    if (rst_ni) begin
      if (out_valid_i && out_ready_i) begin
        if (cost_due_q.size() == 0) begin
          $error("unexpected output transaction: total_cost %0d overflow %0b",
                 out_data_i.total_cost, out_data_i.overflow);
          fail_count++;
        end else begin
          due = cost_due_q.pop_front();
          if (out_data_i.total_cost !== due.total_cost) begin
            $error("total_cost mismatch: expected %0d, actual %0d",
                   due.total_cost, out_data_i.total_cost);
            fail_count++;
          end
          if (out_data_i.overflow !== due.overflow) begin
            $error("overflow mismatch: expected %0b, actual %0b",
                   due.overflow, out_data_i.overflow);
            fail_count++;
          end
        end
      end

      if (in_valid_i && in_ready_i) begin
        // keys past capacity are dropped but remembered
        if (keys_held < MAX_KEYS) begin
          freq_mirror[keys_held] = in_data_i.frequency;
          keys_held++;
        end else begin
          excess_seen = 1'b1;
        end
        if (in_data_i.last_key) begin
          due.total_cost = min_tree_cost(keys_held);
          due.overflow   = excess_seen;
          cost_due_q.push_back(due);
          keys_held   = 0;
          excess_seen = 1'b0;
        end
      end

      due_count = cost_due_q.size();
    end
  end

endmodule

// File: tb/tb_optimal_bst_cost_unit.sv
// ----------------------------------------------------------------------------
// Optimal BST cost unit testbench
// Sends sets of key frequencies, from a short directed run through random
// sets of mixed sizes, overflow sets among them, with random idle bursts on
// both channels. A checker beside the unit predicts and compares every cost.
// ----------------------------------------------------------------------------
module tb_optimal_bst_cost_unit;

  localparam int          NKEYS        = obst_pkg::DEF_MAX_KEYS;
  localparam int          FW           = obst_pkg::FREQ_W;
  localparam int          RANDOM_ITEMS = 700;
  localparam int          CALM_ITEMS   = 100;
  localparam int          DRAIN_CYCLES = 1200;
  localparam int unsigned STALL_LIMIT  = 6000;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  obst_pkg::in_item_t  in_data   = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  obst_pkg::out_item_t out_data;

  int unsigned fail_count;
  int unsigned due_count;
  int unsigned keys_sent  = 0;
  int unsigned gap_odds   = 0;
  logic        calm       = 1'b0;
  int unsigned quiet_run  = 0;

  always #4 clk = ~clk;

  optimal_bst_cost_unit #(
    .MAX_KEYS (NKEYS)
  ) dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  optimal_bst_cost_checker #(
    .MAX_KEYS (NKEYS)
  ) u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_data_i   (out_data),
    .fail_count_o (fail_count),
    .due_count_o  (due_count)
  );

  // One input transaction, with an optional idle burst ahead of it
  task automatic send_key(input logic [FW-1:0] freq, input logic last);
    if (!calm && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{frequency: freq, last_key: last};
    do @(posedge clk); while (!in_ready);
    keys_sent++;
  endtask

  // Hold the input until every cost due has come out
  task automatic drain;
    in_valid <= 1'b0;
    do @(negedge clk); while (due_count != 0);
    @(posedge clk);
  endtask

  function automatic logic [FW-1:0] pick_freq;
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3:    return FW'($urandom_range(0, 15));
      default: return FW'($urandom_range(0, 65535));
    endcase
  endfunction

  // Receiver: random stall bursts, some long ready stretches
  initial begin
    forever begin
      @(posedge clk);
      if (!calm && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end else if ($urandom_range(0, 15) == 0) begin
        out_ready <= 1'b1;
        repeat ($urandom_range(20, 120)) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_run <= 0;
    end else begin
      quiet_run <= quiet_run + 1;
      if (quiet_run >= STALL_LIMIT) begin
        $display("[optimal_bst_cost_unit] ERROR");
        $finish;
      end
    end
  end

  // Stimulus and verdict
  initial begin
    int unsigned set_len;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed: single keys at both extremes
    send_key('0, 1'b1);
    send_key('1, 1'b1);
    // a short mixed set
    send_key(16'd1, 1'b0);
    send_key('1, 1'b0);
    send_key('0, 1'b1);
    // full store of maximal keys, then the flag on a dropped key
    for (int i = 0; i <= NKEYS; i++) send_key('1, i == NKEYS);
    drain();

    // random sets, mostly small, some full and some past capacity
    while (keys_sent < RANDOM_ITEMS) begin
      if (keys_sent >= RANDOM_ITEMS - CALM_ITEMS) calm = 1'b1;
      case ($urandom_range(0, 19))
        0:       set_len = $urandom_range(NKEYS + 1, NKEYS + 4);
        1, 2, 3: set_len = $urandom_range(7, NKEYS);
        default: set_len = $urandom_range(1, 6);
      endcase
      gap_odds = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 8);
      for (int i = 0; i < set_len; i++) send_key(pick_freq(), i == set_len - 1);
      if (!calm && $urandom_range(0, 39) == 0) drain();
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && due_count == 0) begin
      $display("[optimal_bst_cost_unit] OK");
    end else begin
      $display("[optimal_bst_cost_unit] ERROR");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+sv
sv/obst_pkg.sv
sv/obst_ram.sv
sv/obst_cmp.sv
sv/obst_ctrl.sv
sv/optimal_bst_cost_unit.sv
tb/optimal_bst_cost_checker.sv
tb/tb_optimal_bst_cost_unit.sv
